// ===== hw/rtl/drhe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drhe_pkg
// Types and constants shared by the decimal round-half-even core.
// ----------------------------------------------------------------------------
package drhe_pkg;

	localparam int unsigned MANT_W        = 96;
	localparam int unsigned LIMB_W        = 16;
	localparam int unsigned LIMBS_PER_DIV = MANT_W / LIMB_W;
	localparam int unsigned REM_W         = 4;
	localparam int unsigned SCALE_W       = 5;
	localparam int unsigned X_W           = REM_W + LIMB_W;
	localparam int unsigned PROD_W        = 2 * X_W;
	localparam int unsigned RECIP_SHIFT   = 23;

	// ceil(2^23 / 10): exact quotient by ten for any numerator below 2^22
	localparam logic [X_W-1:0] RECIP_TEN = X_W'(838861);

	localparam logic [REM_W-1:0] HALF_DIGIT = REM_W'(5);

	typedef struct packed {
		logic [MANT_W-1:0]  mant;
		logic [REM_W-1:0]   rem;
		logic               sticky;
		logic [SCALE_W-1:0] scale;
		logic               negative;
	} item_t;

endpackage
`default_nettype wire

// ===== hw/rtl/drhe_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drhe_cell
// One long-division step by ten on the top 16-bit limb of the mantissa.
// The word is rotated by one limb per cell, so six cells in a row complete
// one division by ten and restore the limb order.
// ----------------------------------------------------------------------------
module drhe_cell #(
	parameter int unsigned GROUP = 0,
	parameter bit          FIRST = 1'b0
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	input  drhe_pkg::item_t  in_item,
	output logic             out_valid,
	output drhe_pkg::item_t  out_item
);

	logic                            active;
	logic [drhe_pkg::LIMB_W-1:0]     top;
	logic [drhe_pkg::REM_W-1:0]      rem_base;
	logic [drhe_pkg::X_W-1:0]        x;
	logic [drhe_pkg::PROD_W-1:0]     prod;
	logic [drhe_pkg::LIMB_W-1:0]     q;
	logic [drhe_pkg::X_W-1:0]        r;
	drhe_pkg::item_t                 nxt;
	logic                            valid_s1;
	drhe_pkg::item_t                 item_s1;

	always_comb begin
		active   = in_item.scale > drhe_pkg::SCALE_W'(GROUP);
		top      = in_item.mant[drhe_pkg::MANT_W-1 -: drhe_pkg::LIMB_W];
		rem_base = FIRST ? '0 : in_item.rem;
		x        = {rem_base, top};
		prod     = drhe_pkg::PROD_W'(x) * drhe_pkg::PROD_W'(drhe_pkg::RECIP_TEN);
		q        = prod[drhe_pkg::RECIP_SHIFT +: drhe_pkg::LIMB_W];
		r        = x - (drhe_pkg::X_W'(q) << 3) - (drhe_pkg::X_W'(q) << 1);

		nxt          = in_item;
		nxt.mant     = {in_item.mant[drhe_pkg::MANT_W-drhe_pkg::LIMB_W-1:0], active ? q : top};
		nxt.rem      = active ? r[drhe_pkg::REM_W-1:0] : in_item.rem;
		nxt.sticky   = in_item.sticky | (FIRST & active & (in_item.rem != '0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= nxt;
	end

	assign out_valid = valid_s1;
	assign out_item  = item_s1;

endmodule
`default_nettype wire

// ===== hw/rtl/drhe_round.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drhe_round
// Round-half-even decision on the last digit and sticky bit, increment of
// the quotient and the registered result beat.
// ----------------------------------------------------------------------------
module drhe_round (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	input  drhe_pkg::item_t              in_item,
	output logic                         done,
	output logic [drhe_pkg::MANT_W-1:0]  rounded,
	output logic                         rounded_negative
);

	logic                        up;
	logic [drhe_pkg::MANT_W-1:0] sum;
	logic                        done_q;
	logic [drhe_pkg::MANT_W-1:0] rounded_q;
	logic                        negative_q;

	always_comb begin
		up = (in_item.rem > drhe_pkg::HALF_DIGIT) ||
		     ((in_item.rem == drhe_pkg::HALF_DIGIT) && (in_item.sticky || in_item.mant[0]));
		sum = in_item.mant + drhe_pkg::MANT_W'(up);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		rounded_q  <= sum;
		negative_q <= in_item.negative;
	end

	assign done             = done_q;
	assign rounded          = rounded_q;
	assign rounded_negative = negative_q;

endmodule
`default_nettype wire

// ===== hw/rtl/decimal_round_half_even_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_round_half_even_core
// Rounds sign, 96-bit mantissa and scale to an integer, half to even.
// ----------------------------------------------------------------------------
// A new number is taken on every clock edge with start high; busy stays low
// and the receiver cannot stall. Each result appears for one cycle with done
// high, in order, after the input register, the row of division cells and
// the output register. Each cell divides one 16-bit limb by ten, six cells
// make one decimal digit, and there is one group of six for every scale
// step up to MAX_SCALE. Scales above MAX_SCALE saturate to MAX_SCALE.
// ----------------------------------------------------------------------------
module decimal_round_half_even_core #(
	parameter int unsigned MAX_SCALE = 28
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire  [63:0] mantissa_low,
	input  wire  [31:0] mantissa_high,
	input  wire  [4:0]  scale,
	input  wire         negative,
	output logic        done,
	output logic [63:0] rounded_low,
	output logic [31:0] rounded_high,
	output logic        rounded_negative
);

	localparam int unsigned NCELLS = MAX_SCALE * drhe_pkg::LIMBS_PER_DIV;
	localparam logic [drhe_pkg::SCALE_W-1:0] SCALE_LIMIT = drhe_pkg::SCALE_W'(MAX_SCALE);

	logic                        valid_s0;
	drhe_pkg::item_t             item_s0;
	drhe_pkg::item_t             load;
	logic                        chain_valid [NCELLS+1];
	drhe_pkg::item_t             chain_item  [NCELLS+1];
	logic [drhe_pkg::MANT_W-1:0] rounded;

	assign busy = 1'b0;

	always_comb begin
		load.mant     = {mantissa_high, mantissa_low};
		load.rem      = '0;
		load.sticky   = 1'b0;
		load.scale    = (scale > SCALE_LIMIT) ? SCALE_LIMIT : scale;
		load.negative = negative;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else begin
			valid_s0 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		item_s0 <= load;
	end

	assign chain_valid[0] = valid_s0;
	assign chain_item[0]  = item_s0;

	for (genvar i = 0; i < NCELLS; i++) begin : g_cell
		drhe_cell #(
			.GROUP (i / drhe_pkg::LIMBS_PER_DIV),
			.FIRST ((i % drhe_pkg::LIMBS_PER_DIV) == 0)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[i]),
			.in_item   (chain_item[i]),
			.out_valid (chain_valid[i+1]),
			.out_item  (chain_item[i+1])
		);
	end

	drhe_round u_round (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (chain_valid[NCELLS]),
		.in_item          (chain_item[NCELLS]),
		.done             (done),
		.rounded          (rounded),
		.rounded_negative (rounded_negative)
	);

	assign rounded_low  = rounded[63:0];
	assign rounded_high = rounded[95:64];

endmodule
`default_nettype wire

// ===== hw/rtl/drhe_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drhe_checker
// Port-level checks on latency, sign and pass-through of the rounding core.
// ----------------------------------------------------------------------------
module drhe_checker #(
	parameter int unsigned MAX_SCALE = 28
) (
	input wire        clk,
	input wire        arst_n,
	input wire        start,
	input wire        busy,
	input wire [63:0] mantissa_low,
	input wire [31:0] mantissa_high,
	input wire [4:0]  scale,
	input wire        negative,
	input wire        done,
	input wire [63:0] rounded_low,
	input wire [31:0] rounded_high,
	input wire        rounded_negative
);

	localparam int unsigned LAT = MAX_SCALE * drhe_pkg::LIMBS_PER_DIV + 2;

	a_beat_out: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("start beat without result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without start beat");

	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rounded_negative == $past(negative, LAT)))
		else $error("sign not carried");

	a_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ($past(scale, LAT) == 5'd0)) |->
		((rounded_low == $past(mantissa_low, LAT)) &&
		 (rounded_high == $past(mantissa_high, LAT))))
		else $error("scale zero altered mantissa");

endmodule

bind decimal_round_half_even_core drhe_checker #(
	.MAX_SCALE (MAX_SCALE)
) u_drhe_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.start            (start),
	.busy             (busy),
	.mantissa_low     (mantissa_low),
	.mantissa_high    (mantissa_high),
	.scale            (scale),
	.negative         (negative),
	.done             (done),
	.rounded_low      (rounded_low),
	.rounded_high     (rounded_high),
	.rounded_negative (rounded_negative)
);
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the decimal round-half-even core. A directed table
// covers the field extremes, exact and near ties on both sides, negative zero,
// a carry into the upper word and scales above the maximum. Random numbers
// follow, partly built around rounding ties at random scales. They are sent
// under several sender gap patterns. Every result is checked field by field
// against the expected value typed in the table or an in-bench model of the rounding.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int unsigned MAX_SCALE   = 28;
	localparam int unsigned LATENCY     = 6 * MAX_SCALE + 2;
	localparam int unsigned CYCLE_LIMIT = 100000;
	localparam int unsigned PHASE_BEATS = 200;
	localparam int unsigned IDLE_PCT [4] = '{0, 50, 0, 17};
	localparam logic [95:0] MAX96 = 96'hFFFF_FFFF_FFFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic [95:0] mant;
		logic [4:0]  scale;
		logic        neg;
		logic        typed;
		logic [95:0] want;
	} dir_row_t;

	typedef struct packed {
		logic [95:0] mag;
		logic        neg;
	} rounded_t;

	localparam int unsigned N_DIRECTED = 25;
	localparam dir_row_t DIRECTED [N_DIRECTED] = '{
		'{96'd0,                                 5'd0,  1'b0, 1'b1, 96'd0},
		'{MAX96,                                 5'd0,  1'b1, 1'b1, MAX96},
		'{MAX96,                                 5'd28, 1'b0, 1'b1, 96'd8},
		'{96'd0,                                 5'd28, 1'b1, 1'b1, 96'd0},
		'{96'd25,                                5'd1,  1'b0, 1'b1, 96'd2},
		'{96'd35,                                5'd1,  1'b0, 1'b1, 96'd4},
		'{96'd26,                                5'd1,  1'b1, 1'b1, 96'd3},
		'{96'd24,                                5'd1,  1'b0, 1'b1, 96'd2},
		'{96'd5,                                 5'd1,  1'b1, 1'b1, 96'd0},
		'{96'd15,                                5'd1,  1'b0, 1'b1, 96'd2},
		'{96'd2501,                              5'd2,  1'b0, 1'b1, 96'd25},
		'{96'd250,                               5'd2,  1'b0, 1'b1, 96'd2},
		'{96'd251,                               5'd2,  1'b1, 1'b1, 96'd3},
		'{96'd35_000000000_000000000_000000000,  5'd29, 1'b0, 1'b1, 96'd4},
		'{MAX96,                                 5'd31, 1'b1, 1'b1, 96'd8},
		'{96'd25_000000000_000000000_000000000,  5'd30, 1'b0, 1'b1, 96'd2},
		'{96'd5_000000000_000000000_000000000,   5'd28, 1'b0, 1'b1, 96'd0},
		'{96'd15_000000000_000000000_000000000,  5'd28, 1'b1, 1'b1, 96'd2},
		'{96'h9_FFFF_FFFF_FFFF_FFFB,             5'd1,  1'b0, 1'b1,
			96'h1_0000_0000_0000_0000},
		'{96'h1_0000_0000_0000_0000,             5'd0,  1'b0, 1'b1,
			96'h1_0000_0000_0000_0000},
		'{96'd15_000000000,                      5'd10, 1'b0, 1'b1, 96'd2},
		'{MAX96,                                 5'd9,  1'b0, 1'b0, 96'd0},
		'{MAX96,                                 5'd19, 1'b1, 1'b0, 96'd0},
		'{96'hFFFF_FFFF_FFFF_FFFF,               5'd1,  1'b0, 1'b0, 96'd0},
		'{96'hAAAA_AAAA_5555_5555_F0F0_F0F0,     5'd14, 1'b1, 1'b0, 96'd0}
	};

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        start         = 1'b0;
	logic [63:0] mantissa_low  = '0;
	logic [31:0] mantissa_high = '0;
	logic [4:0]  scale         = '0;
	logic        negative      = 1'b0;
	logic        busy;
	logic        done;
	logic [63:0] rounded_low;
	logic [31:0] rounded_high;
	logic        rounded_negative;

	rounded_t    pending_rounds [$];
	int unsigned err_count   = 0;
	int unsigned cycle_count = 0;

	decimal_round_half_even_core #(
		.MAX_SCALE(MAX_SCALE)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mantissa_low(mantissa_low),
		.mantissa_high(mantissa_high),
		.scale(scale),
		.negative(negative),
		.done(done),
		.rounded_low(rounded_low),
		.rounded_high(rounded_high),
		.rounded_negative(rounded_negative)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [127:0] pow10(input int unsigned n);
		logic [127:0] p;
		p = 128'd1;
		for (int unsigned i = 0; i < n; i++)
			p = p * 10;
		return p;
	endfunction

	function automatic int unsigned clamp_scale(input logic [4:0] s);
		return (s > MAX_SCALE) ? MAX_SCALE : int'(s);
	endfunction

	// divide by 10^scale, round half to even
	function automatic logic [95:0] round_half_even(input logic [95:0] m, input logic [4:0] s);
		logic [127:0] d;
		logic [127:0] q;
		logic [127:0] r;
		int unsigned  eff;
		eff = clamp_scale(s);
		if (eff == 0)
			return m;
		d = pow10(eff);
		q = {32'd0, m} / d;
		r = {32'd0, m} % d;
		if ((r * 2 > d) || ((r * 2 == d) && q[0]))
			q = q + 1;
		return q[95:0];
	endfunction

	function automatic logic [95:0] rand96();
		return {$urandom(), $urandom(), $urandom()};
	endfunction

	function automatic logic [4:0] pick_scale();
		if ($urandom_range(99) < 4)
			return 5'($urandom_range(29, 31));
		return 5'($urandom_range(0, MAX_SCALE));
	endfunction

	// in four of ten cases quotient * 10^scale plus a remainder, mostly at or near half the divisor
	function automatic logic [95:0] pick_mantissa(input logic [4:0] s);
		logic [127:0] p;
		logic [127:0] q;
		logic [127:0] r;
		logic [127:0] m;
		int unsigned  len;
		p = pow10(clamp_scale(s));
		case ($urandom_range(9))
			0, 1, 2: m = {32'd0, rand96()};
			3, 4: begin
				len = $urandom_range(1, 96);
				m = {32'd0, rand96()} & ((128'd1 << len) - 1);
			end
			9: m = {32'd0, MAX96} - $urandom_range(0, 1023);
			default: begin
				q = {32'd0, rand96()} % (((128'd1 << 96) - 1) / p);
				if ($urandom_range(1))
					q = q % 1000;
				if (p == 1)
					r = 0;
				else begin
					case ($urandom_range(5))
						0, 1: r = p / 2;
						2: r = p / 2 - 1;
						3: r = p / 2 + 1;
						4: r = {32'd0, rand96()} % p;
						default: r = p - 1;
					endcase
				end
				m = q * p + r;
			end
		endcase
		return m[95:0];
	endfunction

	task automatic send_number(input logic [95:0] m, input logic [4:0] s, input logic n,
			input logic [95:0] want, input int unsigned idle_pct);
		start         <= 1'b1;
		mantissa_low  <= m[63:0];
		mantissa_high <= m[95:64];
		scale         <= s;
		negative      <= n;
		do @(posedge clk); while (busy);
		pending_rounds.push_back('{mag: want, neg: n});
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
	endtask

	always @(posedge clk) begin : check_results
		rounded_t want;
		if (arst_n && done) begin
			if (pending_rounds.size() == 0) begin
				$display("%0t: unexpected beat, got %h %h %b", $time,
					rounded_high, rounded_low, rounded_negative);
				err_count++;
			end else begin
				want = pending_rounds.pop_front();
				if (rounded_low !== want.mag[63:0]) begin
					$display("%0t: rounded_low expected %h, got %h", $time,
						want.mag[63:0], rounded_low);
					err_count++;
				end
				if (rounded_high !== want.mag[95:64]) begin
					$display("%0t: rounded_high expected %h, got %h", $time,
						want.mag[95:64], rounded_high);
					err_count++;
				end
				if (rounded_negative !== want.neg) begin
					$display("%0t: rounded_negative expected %b, got %b", $time,
						want.neg, rounded_negative);
					err_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		logic [95:0] m;
		logic [4:0]  s;
		logic        n;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (int unsigned i = 0; i < N_DIRECTED; i++)
			send_number(DIRECTED[i].mant, DIRECTED[i].scale, DIRECTED[i].neg,
				DIRECTED[i].typed ? DIRECTED[i].want
					: round_half_even(DIRECTED[i].mant, DIRECTED[i].scale), 0);

		for (int unsigned ph = 0; ph < 4; ph++) begin
			repeat (PHASE_BEATS) begin
				s = pick_scale();
				m = pick_mantissa(s);
				n = 1'($urandom_range(1));
				send_number(m, s, n, round_half_even(m, s), IDLE_PCT[ph]);
			end
		end
		start <= 1'b0;

		while (pending_rounds.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);

		if (err_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
